// ===== src/tpcc_pkg.sv =====
// Package for the triangle pair candidate generator.
// Holds the slot kind codes, the slot position type and small index helpers.
// No dependencies; all modules import it and the result interface refers to it.
package tpcc_pkg;

  // Slot kinds as seen on the result channel
  typedef enum logic [1:0] {
    KIND_EMPTY       = 2'd0,
    KIND_EDGE_EDGE   = 2'd1,
    KIND_VERTEX_FACE = 2'd2
  } pair_kind_e;

  localparam int unsigned SLOT_BITS = 4;

  // Last vertex-face slot and last column of an edge-edge row
  localparam logic [2:0] LAST_VF  = 3'd5;
  localparam logic [2:0] B_VF_OFS = 3'd3;
  localparam logic [1:0] LAST_COL = 2'd2;

  // Position inside the candidate array of the item in flight
  typedef struct packed {
    logic       ee;   // 0: vertex-face phase, 1: edge-edge phase
    logic [2:0] vf;   // vertex-face slot 0..5
    logic [1:0] row;  // edge of A
    logic [1:0] col;  // edge of B
  } slot_pos_t;

  // Result of a search for the next owned edge row
  typedef struct packed {
    logic       found;
    logic [1:0] row;
  } row_hit_t;

  // Next vertex around the triangle
  function automatic logic [1:0] next_of(logic [1:0] k);
    logic [1:0] n;
    case (k)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // First set bit of mask at or above position from (from may be 3: none)
  function automatic row_hit_t row_search(logic [2:0] mask, logic [1:0] from);
    logic [2:0] m;
    row_hit_t   hit;
    case (from)
      2'd0:    m = mask;
      2'd1:    m = mask & 3'b110;
      2'd2:    m = mask & 3'b100;
      default: m = 3'b000;
    endcase
    hit = '0;
    if (m[0]) begin
      hit = '{found: 1'b1, row: 2'd0};
    end else if (m[1]) begin
      hit = '{found: 1'b1, row: 2'd1};
    end else if (m[2]) begin
      hit = '{found: 1'b1, row: 2'd2};
    end
    return hit;
  endfunction

endpackage

// ===== src/tpcc_ifs.sv =====
// Channel interfaces of the triangle pair candidate generator:
// input item, result item and configuration write channel.
// Depends on tpcc_pkg.
interface tpcc_item_if #(parameter int unsigned VW = 24);
  logic          valid;
  logic          ready;
  logic [VW-1:0] a_vertex_0;
  logic [VW-1:0] a_vertex_1;
  logic [VW-1:0] a_vertex_2;
  logic [VW-1:0] b_vertex_0;
  logic [VW-1:0] b_vertex_1;
  logic [VW-1:0] b_vertex_2;
  logic [2:0]    a_vertex_owned;
  logic [2:0]    a_edge_owned;
  logic [2:0]    b_vertex_owned;
  logic [2:0]    b_edge_owned;

  modport source (output valid, a_vertex_0, a_vertex_1, a_vertex_2,
                  b_vertex_0, b_vertex_1, b_vertex_2, a_vertex_owned,
                  a_edge_owned, b_vertex_owned, b_edge_owned, input ready);
  modport sink   (input valid, a_vertex_0, a_vertex_1, a_vertex_2,
                  b_vertex_0, b_vertex_1, b_vertex_2, a_vertex_owned,
                  a_edge_owned, b_vertex_owned, b_edge_owned, output ready);
endinterface

interface tpcc_result_if #(parameter int unsigned VW = 24);
  logic                                 valid;
  logic                                 ready;
  tpcc_pkg::pair_kind_e                 pair_kind;
  logic [VW-1:0]                        stencil_0;
  logic [VW-1:0]                        stencil_1;
  logic [VW-1:0]                        stencil_2;
  logic [VW-1:0]                        stencil_3;
  logic [tpcc_pkg::SLOT_BITS-1:0]       slot_number;
  logic                                 last_slot;

  modport source (output valid, pair_kind, stencil_0, stencil_1, stencil_2,
                  stencil_3, slot_number, last_slot, input ready);
  modport sink   (input valid, pair_kind, stencil_0, stencil_1, stencil_2,
                  stencil_3, slot_number, last_slot, output ready);
endinterface

interface tpcc_cfg_if;
  logic valid;
  logic ready;
  logic edge_pairs_enabled;

  modport source (output valid, edge_pairs_enabled, input ready);
  modport sink   (input valid, edge_pairs_enabled, output ready);
endinterface

// ===== src/tpcc_slot_seq.sv =====
// Item register and slot sequencer: holds the accepted triangle pair and
// walks the candidate array one slot per emitted beat, skipping unowned rows.
// Depends on tpcc_pkg and tpcc_item_if.
module tpcc_slot_seq #(
  parameter int unsigned VW = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tpcc_item_if.sink                      in_i,
  input  logic                           edge_en_i,
  input  logic                           emit_i,
  output logic                           item_valid_o,
  output logic [2:0][VW-1:0]             a_vtx_o,
  output logic [2:0][VW-1:0]             b_vtx_o,
  output logic [2:0]                     a_vown_o,
  output logic [2:0]                     b_vown_o,
  output logic [2:0]                     b_eown_o,
  output tpcc_pkg::slot_pos_t            pos_o,
  output logic [tpcc_pkg::SLOT_BITS-1:0] slot_o,
  output logic                           last_o
);
  import tpcc_pkg::*;

  logic                 item_valid_q;
  logic [2:0][VW-1:0]   a_vtx_q, b_vtx_q;
  logic [2:0]           a_vown_q, b_vown_q, a_eown_q, b_eown_q;
  slot_pos_t            pos_q, pos_d;
  logic [SLOT_BITS-1:0] slot_q;
  logic [2:0]           row_mask;
  row_hit_t             first_hit, after_hit;
  logic                 last;
  logic                 accept;

  // Rows of edge-edge slots that will be visited
  assign row_mask  = a_eown_q & {3{edge_en_i}};
  assign first_hit = row_search(row_mask, 2'd0);
  assign after_hit = row_search(row_mask, pos_q.row + 2'd1);

  // Final slot of the item and position of the following slot
  always_comb begin
    pos_d = pos_q;
    if (!pos_q.ee) begin
      last = (pos_q.vf == LAST_VF) && !first_hit.found;
      if (pos_q.vf == LAST_VF) begin
        pos_d.ee  = 1'b1;
        pos_d.row = first_hit.row;
        pos_d.col = 2'd0;
      end else begin
        pos_d.vf = pos_q.vf + 3'd1;
      end
    end else begin
      last = (pos_q.col == LAST_COL) && !after_hit.found;
      if (pos_q.col == LAST_COL) begin
        pos_d.row = after_hit.row;
        pos_d.col = 2'd0;
      end else begin
        pos_d.col = pos_q.col + 2'd1;
      end
    end
  end

  // Take a new item when empty or as the last beat of the current one leaves
  assign in_i.ready = !item_valid_q || (emit_i && last);
  assign accept     = in_i.valid && in_i.ready;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      pos_q        <= '0;
      slot_q       <= '0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
      pos_q        <= '0;
      slot_q       <= '0;
    end else if (emit_i) begin
      if (last) begin
        item_valid_q <= 1'b0;
      end
      pos_q  <= pos_d;
      slot_q <= slot_q + SLOT_BITS'(1);
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_vtx_q  <= {in_i.a_vertex_2, in_i.a_vertex_1, in_i.a_vertex_0};
      b_vtx_q  <= {in_i.b_vertex_2, in_i.b_vertex_1, in_i.b_vertex_0};
      a_vown_q <= in_i.a_vertex_owned;
      a_eown_q <= in_i.a_edge_owned;
      b_vown_q <= in_i.b_vertex_owned;
      b_eown_q <= in_i.b_edge_owned;
    end
  end

  assign item_valid_o = item_valid_q;
  assign a_vtx_o      = a_vtx_q;
  assign b_vtx_o      = b_vtx_q;
  assign a_vown_o     = a_vown_q;
  assign b_vown_o     = b_vown_q;
  assign b_eown_o     = b_eown_q;
  assign pos_o        = pos_q;
  assign slot_o       = slot_q;
  assign last_o       = last;

endmodule

// ===== src/tpcc_slot_fmt.sv =====
// Slot formatter: compares the vertex indices of both triangles and builds
// the kind and stencil of the slot at the current position.
// Depends on tpcc_pkg.
module tpcc_slot_fmt #(
  parameter int unsigned VW = 24
) (
  input  logic [2:0][VW-1:0]    a_vtx_i,
  input  logic [2:0][VW-1:0]    b_vtx_i,
  input  logic [2:0]            a_vown_i,
  input  logic [2:0]            b_vown_i,
  input  logic [2:0]            b_eown_i,
  input  tpcc_pkg::slot_pos_t   pos_i,
  output tpcc_pkg::pair_kind_e  kind_o,
  output logic [VW-1:0]         s0_o,
  output logic [VW-1:0]         s1_o,
  output logic [VW-1:0]         s2_o,
  output logic [VW-1:0]         s3_o
);
  import tpcc_pkg::*;

  logic [2:0][2:0] eq;        // eq[i][j]: A vertex i equals B vertex j
  logic            b_side;
  logic [1:0]      k;
  logic            v_own, v_on_face;
  logic [1:0]      i0, i1, j0, j1;
  logic            touch;

  // All nine index compares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        eq[i][j] = (a_vtx_i[i] == b_vtx_i[j]);
      end
    end
  end

  // Vertex-face slot: which triangle and which vertex
  always_comb begin
    unique case (pos_i.vf)
      3'd0, 3'd1, 3'd2: begin
        b_side = 1'b0;
        k      = pos_i.vf[1:0];
      end
      default: begin
        b_side = 1'b1;
        k      = 2'(pos_i.vf - B_VF_OFS);
      end
    endcase
    if (k == 2'd3) begin
      k = 2'd0;
    end
    v_own     = b_side ? b_vown_i[k] : a_vown_i[k];
    v_on_face = b_side ? (eq[0][k] | eq[1][k] | eq[2][k]) : (|eq[k]);
  end

  // Edge-edge slot: ends of both edges and touch test
  always_comb begin
    i0    = pos_i.row;
    i1    = next_of(pos_i.row);
    j0    = pos_i.col;
    j1    = next_of(pos_i.col);
    touch = eq[i0][j0] | eq[i0][j1] | eq[i1][j0] | eq[i1][j1];
  end

  // Select kind and stencil, zero for an empty slot
  always_comb begin
    kind_o = KIND_EMPTY;
    s0_o   = '0;
    s1_o   = '0;
    s2_o   = '0;
    s3_o   = '0;
    if (!pos_i.ee) begin
      if (v_own && !v_on_face) begin
        kind_o = KIND_VERTEX_FACE;
        if (b_side) begin
          s0_o = b_vtx_i[k];
          s1_o = a_vtx_i[0];
          s2_o = a_vtx_i[1];
          s3_o = a_vtx_i[2];
        end else begin
          s0_o = a_vtx_i[k];
          s1_o = b_vtx_i[0];
          s2_o = b_vtx_i[1];
          s3_o = b_vtx_i[2];
        end
      end
    end else if (b_eown_i[j0] && !touch) begin
      kind_o = KIND_EDGE_EDGE;
      s0_o   = a_vtx_i[i0];
      s1_o   = a_vtx_i[i1];
      s2_o   = b_vtx_i[j0];
      s3_o   = b_vtx_i[j1];
    end
  end

endmodule

// ===== src/triangle_pair_ccd_candidates_top.sv =====
// Top level of the triangle pair candidate generator: configuration
// register, sequencer, slot formatter and result register.
// Depends on tpcc_pkg, tpcc_ifs, tpcc_slot_seq and tpcc_slot_fmt.
// Throughput: one result per cycle through the single result register while
// the receiver is ready; an item has six slots, plus three per edge owned
// by A when edge pairs are enabled.
// The next item is taken as the last beat of the current one moves on.
// Reset: no item held, result channel empty, edge pairs enabled.
module triangle_pair_ccd_candidates_top #(
  parameter int unsigned VERTEX_INDEX_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tpcc_cfg_if.sink         cfg_i,
  tpcc_item_if.sink        in_i,
  tpcc_result_if.source    out_o
);
  import tpcc_pkg::*;

  localparam int unsigned VW = VERTEX_INDEX_BITS;

  logic                 edge_en_q;
  logic                 item_valid;
  logic [2:0][VW-1:0]   a_vtx, b_vtx;
  logic [2:0]           a_vown, b_vown, b_eown;
  slot_pos_t            pos;
  logic [SLOT_BITS-1:0] seq_slot;
  logic                 seq_last;
  logic                 emit;
  pair_kind_e           kind;
  logic [VW-1:0]        s0, s1, s2, s3;

  logic                 out_valid_q;
  pair_kind_e           out_kind_q;
  logic [VW-1:0]        out_s0_q, out_s1_q, out_s2_q, out_s3_q;
  logic [SLOT_BITS-1:0] out_slot_q;
  logic                 out_last_q;

  // Configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      edge_en_q <= cfg_i.edge_pairs_enabled;
    end
  end

  // Move a slot into the result register when it is free or being drained
  assign emit = item_valid && (!out_valid_q || out_o.ready);

  tpcc_slot_seq #(.VW(VW)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .edge_en_i    (edge_en_q),
    .emit_i       (emit),
    .item_valid_o (item_valid),
    .a_vtx_o      (a_vtx),
    .b_vtx_o      (b_vtx),
    .a_vown_o     (a_vown),
    .b_vown_o     (b_vown),
    .b_eown_o     (b_eown),
    .pos_o        (pos),
    .slot_o       (seq_slot),
    .last_o       (seq_last)
  );

  tpcc_slot_fmt #(.VW(VW)) u_fmt (
    .a_vtx_i  (a_vtx),
    .b_vtx_i  (b_vtx),
    .a_vown_i (a_vown),
    .b_vown_i (b_vown),
    .b_eown_i (b_eown),
    .pos_i    (pos),
    .kind_o   (kind),
    .s0_o     (s0),
    .s1_o     (s1),
    .s2_o     (s2),
    .s3_o     (s3)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= kind;
      out_s0_q   <= s0;
      out_s1_q   <= s1;
      out_s2_q   <= s2;
      out_s3_q   <= s3;
      out_slot_q <= seq_slot;
      out_last_q <= seq_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pair_kind   = out_kind_q;
  assign out_o.stencil_0   = out_s0_q;
  assign out_o.stencil_1   = out_s1_q;
  assign out_o.stencil_2   = out_s2_q;
  assign out_o.stencil_3   = out_s3_q;
  assign out_o.slot_number = out_slot_q;
  assign out_o.last_slot   = out_last_q;

  // An empty slot carries an all-zero stencil
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == KIND_EMPTY) |->
      (out_s0_q == '0) && (out_s1_q == '0) && (out_s2_q == '0) && (out_s3_q == '0))
    else $error("empty slot with nonzero stencil");

  // Every item has at least the six vertex-face slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> (out_slot_q >= SLOT_BITS'(LAST_VF)))
    else $error("item ended before its vertex-face slots");

  // The fifteenth slot always closes the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_slot_q == SLOT_BITS'(14)) |-> out_last_q)
    else $error("slot past the end of the candidate array");

  // A slot that is not last is followed by the next slot number of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !seq_last |=> item_valid && (seq_slot == $past(seq_slot) + SLOT_BITS'(1)))
    else $error("slot sequence broken inside an item");

endmodule

// ===== dv/tb_triangle_pair_ccd_candidates_top.sv =====
`timescale 1ns / 100ps
// Testbench for triangle_pair_ccd_candidates_top: directed and random triangle pairs,
// with a scoreboard class that predicts every candidate slot and checks the result beats.
// Depends on tpcc_pkg, the channel interfaces in tpcc_ifs and the top level.
module tb_triangle_pair_ccd_candidates_top;
  import tpcc_pkg::*;

  localparam int unsigned VW          = 24;
  localparam int          QUIET_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 8;

  typedef logic [VW-1:0] vidx_t;

  // One input beat: both triangles and their ownership masks
  typedef struct {
    vidx_t      a [3];
    vidx_t      b [3];
    logic [2:0] a_vo;
    logic [2:0] a_eo;
    logic [2:0] b_vo;
    logic [2:0] b_eo;
  } tri_pair_t;

  // One result beat: a candidate slot
  typedef struct {
    pair_kind_e           kind;
    vidx_t                s0;
    vidx_t                s1;
    vidx_t                s2;
    vidx_t                s3;
    logic [SLOT_BITS-1:0] slot;
    logic                 last;
  } cand_slot_t;

  // Predict candidate slots per accepted pair and check result beats in order
  class candidate_board;
    bit         edge_pairs_en;
    cand_slot_t pending [$];
    int         errors;
    int         next_slot;

    function new();
      edge_pairs_en = 1'b1;
      errors        = 0;
    endfunction

    function bit on_face(vidx_t v, vidx_t f [3]);
      return (v == f[0]) || (v == f[1]) || (v == f[2]);
    endfunction

    function void push_slot(pair_kind_e kind, vidx_t s0, vidx_t s1, vidx_t s2, vidx_t s3);
      cand_slot_t s;
      s.kind = kind;
      s.s0   = s0;
      s.s1   = s1;
      s.s2   = s2;
      s.s3   = s3;
      s.slot = next_slot[SLOT_BITS-1:0];
      s.last = 1'b0;
      pending.push_back(s);
      next_slot++;
    endfunction

    function void note_item(tri_pair_t p);
      vidx_t a0, a1, b0, b1;
      bit    touch;
      next_slot = 0;
      // Vertices of A against face B
      for (int k = 0; k < 3; k++) begin
        if (p.a_vo[k] && !on_face(p.a[k], p.b))
          push_slot(KIND_VERTEX_FACE, p.a[k], p.b[0], p.b[1], p.b[2]);
        else
          push_slot(KIND_EMPTY, '0, '0, '0, '0);
      end
      // Vertices of B against face A
      for (int k = 0; k < 3; k++) begin
        if (p.b_vo[k] && !on_face(p.b[k], p.a))
          push_slot(KIND_VERTEX_FACE, p.b[k], p.a[0], p.a[1], p.a[2]);
        else
          push_slot(KIND_EMPTY, '0, '0, '0, '0);
      end
      // Edge rows only for edges that A owns; skipped rows leave no gap
      if (edge_pairs_en) begin
        for (int i = 0; i < 3; i++) begin
          if (!p.a_eo[i]) continue;
          a0 = p.a[i];
          a1 = p.a[(i + 1) % 3];
          for (int j = 0; j < 3; j++) begin
            b0    = p.b[j];
            b1    = p.b[(j + 1) % 3];
            touch = (a0 == b0) || (a0 == b1) || (a1 == b0) || (a1 == b1);
            if (p.b_eo[j] && !touch)
              push_slot(KIND_EDGE_EDGE, a0, a1, b0, b1);
            else
              push_slot(KIND_EMPTY, '0, '0, '0, '0);
          end
        end
      end
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(cand_slot_t got);
      cand_slot_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: expected none, actual slot %0d",
                 $time, got.slot);
        return;
      end
      want = pending.pop_front();
      compare_field("pair_kind",   want.kind, got.kind);
      compare_field("stencil_0",   want.s0,   got.s0);
      compare_field("stencil_1",   want.s1,   got.s1);
      compare_field("stencil_2",   want.s2,   got.s2);
      compare_field("stencil_3",   want.s3,   got.s3);
      compare_field("slot_number", want.slot, got.slot);
      compare_field("last_slot",   want.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tpcc_cfg_if          cfg_bus ();
  tpcc_item_if   #(VW) item_bus ();
  tpcc_result_if #(VW) res_bus ();

  triangle_pair_ccd_candidates_top #(
    .VERTEX_INDEX_BITS(VW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (item_bus),
    .out_o (res_bus)
  );

  candidate_board board = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int quiet_cycles;

  // Clock: 10 ns period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: end the run after a long stretch with no beat on any channel
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result sink: check each beat, stall at random, hold off on request
  initial begin
    int         stall_left;
    bit         hold_seen;
    cand_slot_t got;
    stall_left    = 0;
    hold_seen     = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        got.kind = res_bus.pair_kind;
        got.s0   = res_bus.stencil_0;
        got.s1   = res_bus.stencil_1;
        got.s2   = res_bus.stencil_2;
        got.s3   = res_bus.stencil_3;
        got.slot = res_bus.slot_number;
        got.last = res_bus.last_slot;
        board.check_result(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic tri_pair_t build_pair(vidx_t a0, vidx_t a1, vidx_t a2,
                                           vidx_t b0, vidx_t b1, vidx_t b2,
                                           logic [2:0] a_vo, logic [2:0] a_eo,
                                           logic [2:0] b_vo, logic [2:0] b_eo);
    tri_pair_t p;
    p.a[0] = a0; p.a[1] = a1; p.a[2] = a2;
    p.b[0] = b0; p.b[1] = b1; p.b[2] = b2;
    p.a_vo = a_vo; p.a_eo = a_eo;
    p.b_vo = b_vo; p.b_eo = b_eo;
    return p;
  endfunction

  // Mostly pairs that share vertices the way mesh neighbors do, some fully random
  function automatic tri_pair_t random_pair();
    tri_pair_t p;
    vidx_t     base;
    base = vidx_t'($urandom);
    for (int k = 0; k < 3; k++) p.a[k] = vidx_t'($urandom);
    case ($urandom_range(3))
      0: begin
        for (int k = 0; k < 3; k++) p.b[k] = vidx_t'($urandom);
      end
      1: begin
        // tight index pool: lots of coincident and degenerate vertices
        for (int k = 0; k < 3; k++) p.a[k] = base ^ vidx_t'($urandom_range(3));
        for (int k = 0; k < 3; k++) p.b[k] = base ^ vidx_t'($urandom_range(3));
      end
      default: begin
        for (int k = 0; k < 3; k++)
          p.b[k] = ($urandom_range(1) == 1) ? p.a[$urandom_range(2)] : vidx_t'($urandom);
      end
    endcase
    p.a_vo = 3'($urandom_range(7));
    p.a_eo = ($urandom_range(1) == 1) ? 3'b111 : 3'($urandom_range(7));
    p.b_vo = 3'($urandom_range(7));
    p.b_eo = 3'($urandom_range(7));
    return p;
  endfunction

  // Offer one pair after an optional gap; return at the edge where it is taken
  task automatic send_pair(tri_pair_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    item_bus.valid          <= 1'b1;
    item_bus.a_vertex_0     <= p.a[0];
    item_bus.a_vertex_1     <= p.a[1];
    item_bus.a_vertex_2     <= p.a[2];
    item_bus.b_vertex_0     <= p.b[0];
    item_bus.b_vertex_1     <= p.b[1];
    item_bus.b_vertex_2     <= p.b[2];
    item_bus.a_vertex_owned <= p.a_vo;
    item_bus.a_edge_owned   <= p.a_eo;
    item_bus.b_vertex_owned <= p.b_vo;
    item_bus.b_edge_owned   <= p.b_eo;
    do @(posedge clk_i); while (!item_bus.ready);
    board.note_item(p);
  endtask

  task automatic send_random(int count);
    repeat (count) send_pair(random_pair());
  endtask

  // Drop valid and wait until every predicted slot has come back
  task automatic drain();
    item_bus.valid <= 1'b0;
    while (board.pending.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_edge_pairs(bit enable);
    cfg_bus.valid              <= 1'b1;
    cfg_bus.edge_pairs_enabled <= enable;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    board.edge_pairs_en = enable;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    tri_pair_t directed [$];
    int        err_total;

    rst_ni                  = 1'b0;
    hold_req                = 1'b0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.edge_pairs_enabled = 1'b0;
    item_bus.valid          = 1'b0;
    item_bus.a_vertex_0     = '0;
    item_bus.a_vertex_1     = '0;
    item_bus.a_vertex_2     = '0;
    item_bus.b_vertex_0     = '0;
    item_bus.b_vertex_1     = '0;
    item_bus.b_vertex_2     = '0;
    item_bus.a_vertex_owned = '0;
    item_bus.a_edge_owned   = '0;
    item_bus.b_vertex_owned = '0;
    item_bus.b_edge_owned   = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // nothing owned, all indices zero
    directed.push_back(build_pair(0, 0, 0, 0, 0, 0, 3'b000, 3'b000, 3'b000, 3'b000));
    // everything owned but every vertex on the other face, every edge touching
    directed.push_back(build_pair(0, 0, 0, 0, 0, 0, 3'b111, 3'b111, 3'b111, 3'b111));
    // disjoint at the top and bottom of the index range: all fifteen slots filled
    directed.push_back(build_pair(24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD, 0, 1, 2,
                                  3'b111, 3'b111, 3'b111, 3'b111));
    directed.push_back(build_pair(0, 1, 2, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD,
                                  3'b111, 3'b111, 3'b111, 3'b111));
    // B owns no edge: edge rows present but empty
    directed.push_back(build_pair(24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD, 0, 1, 2,
                                  3'b111, 3'b111, 3'b111, 3'b000));
    // shared edge between the faces
    directed.push_back(build_pair(10, 11, 12, 11, 10, 13, 3'b111, 3'b111, 3'b111, 3'b111));
    // single shared vertex
    directed.push_back(build_pair(100, 200, 300, 300, 400, 500,
                                  3'b111, 3'b111, 3'b111, 3'b111));
    // degenerate triangles with repeated indices
    directed.push_back(build_pair(5, 5, 5, 6, 6, 7, 3'b111, 3'b111, 3'b111, 3'b111));
    // one vertex and one edge owned on each side, each position in turn
    directed.push_back(build_pair(24'hAAAAAA, 24'h555555, 24'h0F0F0F,
                                  24'hF0F0F0, 24'h333333, 24'hCCCCCC,
                                  3'b001, 3'b001, 3'b001, 3'b001));
    directed.push_back(build_pair(24'hAAAAAA, 24'h555555, 24'h0F0F0F,
                                  24'hF0F0F0, 24'h333333, 24'hCCCCCC,
                                  3'b010, 3'b010, 3'b010, 3'b010));
    directed.push_back(build_pair(24'hAAAAAA, 24'h555555, 24'h0F0F0F,
                                  24'hF0F0F0, 24'h333333, 24'hCCCCCC,
                                  3'b100, 3'b100, 3'b100, 3'b100));
    // partial ownership with a shared corner
    directed.push_back(build_pair(1, 2, 3, 3, 4, 5, 3'b110, 3'b011, 3'b011, 3'b110));
    // identical faces, A skips its middle edge row
    directed.push_back(build_pair(7, 8, 9, 7, 8, 9, 3'b111, 3'b101, 3'b111, 3'b111));
    // A owns no edge: vertex-face slots only
    directed.push_back(build_pair(20, 21, 22, 30, 31, 32, 3'b111, 3'b000, 3'b111, 3'b111));

    // Reset setting (edge pairs on), no idling
    set_idling(0, 0);
    foreach (directed[k]) send_pair(directed[k]);
    drain();

    // Edge pairs off
    write_edge_pairs(1'b0);
    for (int k = 0; k < 6; k++) send_pair(directed[k]);
    send_random(12);
    drain();

    // Edge pairs on, sender idle often
    write_edge_pairs(1'b1);
    set_idling(57, 0);
    send_random(30);
    drain();

    // Receiver stalls often; hold it off long enough to back up the input
    set_idling(0, 57);
    hold_req <= ~hold_req;
    send_random(30);
    drain();

    // Both sides idle now and then, both settings
    write_edge_pairs(1'b0);
    set_idling(11, 11);
    send_random(20);
    drain();

    write_edge_pairs(1'b1);
    send_random(10);
    drain();

    err_total = board.errors + board.pending.size();
    if (err_total == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
